[design/ihp_pkg.sv]
// shared types and constants for the ip header parser
`default_nettype none
package ihp_pkg;

  localparam int IDX_W       = 16;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic             first;
    logic             last;
    logic [1:0]       kind;
  } ihp_beat_t;

endpackage
`default_nettype wire

[design/ihp_front.sv]
// front end: takes input beats, tracks packet state and byte index, forwards packet bytes
`default_nettype none
module ihp_front
  import ihp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_packet_start,
  input  wire logic       in_packet_end,
  input  wire logic [1:0] in_layer_kind,
  input  wire logic       q_full,
  output logic            q_push,
  output ihp_beat_t       q_beat
);

  logic             active_r, active_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign q_push   = acc && (in_packet_start || active_r);

  always_comb begin
    q_beat.data  = in_data_byte;
    q_beat.idx   = in_packet_start ? '0 : idx_r;
    q_beat.first = in_packet_start;
    q_beat.last  = in_packet_end;
    q_beat.kind  = in_layer_kind;
  end

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    if (acc) begin
      if (in_packet_start) begin
        active_nxt = !in_packet_end;
        idx_nxt    = IDX_W'(1);
      end else if (active_r) begin
        active_nxt = !in_packet_end;
        idx_nxt    = (idx_r == '1) ? idx_r : idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // a packet's last beat always closes the packet
  assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_packet_end) |=> !active_r)
    else $error("front still active after last beat");

endmodule
`default_nettype wire

[design/ihp_queue.sv]
// short beat queue between front and back
`default_nettype none
module ihp_queue
  import ihp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  ihp_beat_t      push_beat,
  output logic           full,
  input  wire logic      pop,
  output logic           valid,
  output ihp_beat_t      pop_beat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ihp_beat_t        mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_beat = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_beat;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r == rd_ptr_r) |-> (cnt_r == '0 || cnt_r == CNT_W'(QUEUE_DEPTH)))
    else $error("queue pointers and count disagree");

endmodule
`default_nettype wire

[design/ihp_back.sv]
// back end: header field parse, extension chain walk and result register
`default_nettype none
module ihp_back
  import ihp_pkg::*;
#(
  parameter int MAX_HEADER_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  ihp_beat_t        q_beat,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [11:0]      out_payload_offset,
  output logic [16:0]      out_payload_length,
  output logic [63:0]      out_source_high,
  output logic [63:0]      out_source_low,
  output logic [63:0]      out_dest_high,
  output logic [63:0]      out_dest_low
);

  localparam int OFF_W = $clog2(MAX_HEADER_BYTES);
  localparam logic [OFF_W-1:0] CHAIN_BASE = OFF_W'(40);
  localparam logic [16:0]      MAX_HDR    = 17'(MAX_HEADER_BYTES);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_V4   = 3'd1;
  localparam logic [2:0] PH_V6   = 3'd2;
  localparam logic [2:0] PH_EXT  = 3'd3;
  localparam logic [2:0] PH_FRAG = 3'd4;
  localparam logic [2:0] PH_AUTH = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;

  localparam logic [2:0] ST_TCP       = 3'd0;
  localparam logic [2:0] ST_UDP       = 3'd1;
  localparam logic [2:0] ST_ICMP6     = 3'd2;
  localparam logic [2:0] ST_UNSUP     = 3'd3;
  localparam logic [2:0] ST_NONEXT    = 3'd4;
  localparam logic [2:0] ST_UNHANDLED = 3'd5;
  localparam logic [2:0] ST_TRUNC     = 3'd6;
  localparam logic [2:0] ST_LENERR    = 3'd7;

  localparam logic [1:0] KIND_V4 = 2'd0;
  localparam logic [1:0] KIND_V6 = 2'd1;

  localparam logic [7:0] PROTO_HOPOPT = 8'd0;
  localparam logic [7:0] PROTO_TCP    = 8'h06;
  localparam logic [7:0] PROTO_UDP    = 8'h11;
  localparam logic [7:0] PROTO_ROUTE  = 8'd43;
  localparam logic [7:0] PROTO_FRAG   = 8'd44;
  localparam logic [7:0] PROTO_AUTH   = 8'd51;
  localparam logic [7:0] PROTO_ICMP6  = 8'd58;
  localparam logic [7:0] PROTO_NONEXT = 8'd59;
  localparam logic [7:0] PROTO_DSTOPT = 8'd60;

  localparam logic [5:0] V4_MIN_HDR = 6'd20;
  localparam logic [16:0] V6_FIXED  = 17'd40;

  function automatic logic [2:0] v6_status(input logic [7:0] p);
    logic [2:0] s;
    case (p)
      PROTO_TCP:    s = ST_TCP;
      PROTO_UDP:    s = ST_UDP;
      PROTO_ICMP6:  s = ST_ICMP6;
      PROTO_NONEXT: s = ST_NONEXT;
      default:      s = ST_UNSUP;
    endcase
    return s;
  endfunction

  // parse state
  logic [2:0]       phase_r, phase_nxt;
  logic [5:0]       hdr_r, hdr_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [OFF_W-1:0] chain_off_r, chain_off_nxt;
  logic [63:0]      aw_r [4];
  logic [63:0]      aw_nxt [4];

  // values seen by the current beat
  logic [2:0]       ph;
  logic [5:0]       hdr;
  logic [15:0]      lenf;
  logic [7:0]       proto;
  logic [OFF_W-1:0] coff;
  logic [63:0]      aw [4];

  logic [7:0]       b;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] i_rel;
  logic [1:0]       w;
  logic [11:0]      elen;
  logic [16:0]      nxt;

  logic             do_chain;
  logic [15:0]      ce_off;
  logic             do_finish;
  logic [2:0]       fin_st;
  logic [15:0]      fin_off;
  logic [16:0]      fin_total;

  logic             emit;
  logic [2:0]       st;
  logic [15:0]      off;
  logic [16:0]      plen;

  logic             out_valid_r, out_valid_nxt;

  assign b     = q_beat.data;
  assign i     = q_beat.idx;
  assign i_rel = i - IDX_W'(8);
  assign w     = i_rel[4:3];
  assign q_pop = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    if (q_beat.first) begin
      if (q_beat.kind == KIND_V4) begin
        ph = PH_V4;
      end else if (q_beat.kind == KIND_V6) begin
        ph = PH_V6;
      end else begin
        ph = PH_DONE;
      end
      hdr  = '0;
      lenf = '0;
      proto = '0;
      coff = CHAIN_BASE;
      for (int k = 0; k < 4; k++) begin
        aw[k] = '0;
      end
    end else begin
      ph    = phase_r;
      hdr   = hdr_r;
      lenf  = len_r;
      proto = proto_r;
      coff  = chain_off_r;
      for (int k = 0; k < 4; k++) begin
        aw[k] = aw_r[k];
      end
    end
  end

  always_comb begin
    phase_nxt     = ph;
    hdr_nxt       = hdr;
    len_nxt       = lenf;
    proto_nxt     = proto;
    chain_off_nxt = coff;
    for (int k = 0; k < 4; k++) begin
      aw_nxt[k] = aw[k];
    end
    elen      = '0;
    nxt       = '0;
    do_chain  = 1'b0;
    ce_off    = '0;
    do_finish = 1'b0;
    fin_st    = ST_UNSUP;
    fin_off   = '0;
    fin_total = '0;
    emit      = 1'b0;
    st        = ST_TCP;
    off       = '0;
    plen      = '0;

    if (q_beat.first && q_beat.kind != KIND_V4 && q_beat.kind != KIND_V6) begin
      emit = 1'b1;
      st   = ST_UNHANDLED;
    end

    case (ph)
      PH_V4: begin
        if (i == IDX_W'(0)) hdr_nxt = {b[3:0], 2'b00};
        if (i == IDX_W'(2)) len_nxt = {b, 8'h00};
        if (i == IDX_W'(3)) len_nxt = lenf | {8'h00, b};
        if (i == IDX_W'(9)) proto_nxt = b;
        if (i >= IDX_W'(12) && i <= IDX_W'(15)) aw_nxt[1] = {32'h0, aw[1][23:0], b};
        if (i >= IDX_W'(16) && i <= IDX_W'(19)) aw_nxt[3] = {32'h0, aw[3][23:0], b};
        if (i == IDX_W'(19)) begin
          if (hdr < V4_MIN_HDR) begin
            emit = 1'b1;
            st   = ST_LENERR;
            off  = 16'(hdr);
          end else begin
            do_finish = 1'b1;
            fin_st    = (proto == PROTO_TCP) ? ST_TCP :
                        (proto == PROTO_UDP) ? ST_UDP : ST_UNSUP;
            fin_off   = 16'(hdr);
            fin_total = {1'b0, lenf};
          end
        end
      end
      PH_V6: begin
        if (i == IDX_W'(4)) len_nxt = {b, 8'h00};
        if (i == IDX_W'(5)) len_nxt = lenf | {8'h00, b};
        if (i == IDX_W'(6)) proto_nxt = b;
        if (i >= IDX_W'(8) && i <= IDX_W'(39)) aw_nxt[w] = {aw[w][55:0], b};
        if (i == IDX_W'(39)) begin
          do_chain = 1'b1;
          ce_off   = 16'(coff);
        end
      end
      PH_EXT, PH_FRAG, PH_AUTH: begin
        if (i == IDX_W'(coff)) begin
          proto_nxt = b;
        end else if ({1'b0, i} == 17'(coff) + 17'd1) begin
          if (ph == PH_FRAG) begin
            elen = 12'd8;
          end else if (ph == PH_AUTH) begin
            elen = {1'b0, ({1'b0, b} + 9'd2), 2'b00};
          end else begin
            elen = {({1'b0, b} + 9'd1), 3'b000};
          end
          nxt = 17'(coff) + 17'(elen);
          if (nxt >= MAX_HDR) begin
            emit = 1'b1;
            st   = ST_LENERR;
          end else begin
            chain_off_nxt = nxt[OFF_W-1:0];
            do_chain      = 1'b1;
            ce_off        = nxt[15:0];
          end
        end
      end
      default: begin
      end
    endcase

    // chain end: either another extension header or the final protocol
    if (do_chain) begin
      case (proto)
        PROTO_HOPOPT, PROTO_ROUTE, PROTO_DSTOPT: phase_nxt = PH_EXT;
        PROTO_FRAG:                              phase_nxt = PH_FRAG;
        PROTO_AUTH:                              phase_nxt = PH_AUTH;
        default: begin
          do_finish = 1'b1;
          fin_st    = v6_status(proto);
          fin_off   = ce_off;
          fin_total = {1'b0, lenf} + V6_FIXED;
        end
      endcase
    end

    // length check against the packet length
    if (do_finish) begin
      emit = 1'b1;
      off  = fin_off;
      if ({1'b0, fin_off} > fin_total) begin
        st   = ST_LENERR;
        plen = '0;
      end else begin
        st   = fin_st;
        plen = fin_total - {1'b0, fin_off};
      end
    end

    if (emit) begin
      phase_nxt = PH_DONE;
    end

    if (q_beat.last) begin
      if (!emit && ph != PH_DONE) begin
        emit = 1'b1;
        st   = ST_TRUNC;
        off  = '0;
        plen = '0;
      end
      phase_nxt = PH_IDLE;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (q_pop && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hdr_r       <= hdr_nxt;
      len_r       <= len_nxt;
      proto_r     <= proto_nxt;
      chain_off_r <= chain_off_nxt;
      for (int k = 0; k < 4; k++) begin
        aw_r[k] <= aw_nxt[k];
      end
    end
    if (q_pop && emit) begin
      out_status         <= st;
      out_payload_offset <= off[11:0];
      out_payload_length <= plen;
      out_source_high    <= aw_nxt[0];
      out_source_low     <= aw_nxt[1];
      out_dest_high      <= aw_nxt[2];
      out_dest_low       <= aw_nxt[3];
    end
  end

  assign out_valid = out_valid_r;

  // the front only forwards beats that belong to a packet
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_beat.first || phase_r != PH_IDLE))
    else $error("beat outside a packet reached the back end");

  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_EXT || phase_r == PH_FRAG || phase_r == PH_AUTH)
      |-> (chain_off_r >= CHAIN_BASE))
    else $error("extension offset below fixed header");

endmodule
`default_nettype wire

[design/ip_header_parser.sv]
// top level of the ip header parser: front end, beat queue and back end
//
//   channel | ports                                   | dir | handshake
//   --------+-----------------------------------------+-----+----------------
//   in      | in_data_byte, in_packet_start,          | in  | in_valid/in_ready
//           | in_packet_end, in_layer_kind            |     |
//   out     | out_status, out_payload_offset,         | out | out_valid/out_ready
//           | out_payload_length, out_source_*,       |     |
//           | out_dest_*                              |     |
//
// one beat per cycle sustained unless a pending result waits on out_ready; a result
// passes through the queue register, then the result register
// reset: synchronous, active low; clears packet tracking, queue and result valid
// a two-entry queue lets the front keep taking beats while a result waits
// for out_ready; in_ready drops only when that queue is full
`default_nettype none
module ip_header_parser
  import ihp_pkg::*;
#(
  parameter int MAX_HEADER_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_packet_start,
  input  wire logic        in_packet_end,
  input  wire logic [1:0]  in_layer_kind,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [11:0]      out_payload_offset,
  output logic [16:0]      out_payload_length,
  output logic [63:0]      out_source_high,
  output logic [63:0]      out_source_low,
  output logic [63:0]      out_dest_high,
  output logic [63:0]      out_dest_low
);

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  ihp_beat_t push_beat;
  ihp_beat_t pop_beat;

  ihp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_packet_start (in_packet_start),
    .in_packet_end   (in_packet_end),
    .in_layer_kind   (in_layer_kind),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_beat          (push_beat)
  );

  ihp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_beat (push_beat),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_beat  (pop_beat)
  );

  ihp_back #(
    .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_beat             (pop_beat),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length),
    .out_source_high    (out_source_high),
    .out_source_low     (out_source_low),
    .out_dest_high      (out_dest_high),
    .out_dest_low       (out_dest_low)
  );

endmodule
`default_nettype wire
